// File: rtl/sxc_pkg.sv
// ----------------------------------------------------------------------------
// sxc_pkg
// Shared widths, types and codes of the subarray XOR counter.
// ----------------------------------------------------------------------------
package sxc_pkg;

    // field widths of the stream words
    localparam int VALUE_W     = 10;
    localparam int TARGET_W    = 10;
    localparam int MATCH_W     = 17;
    localparam int TOTAL_W     = 32;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_PAD_W   = OUT_TDATA_W - MATCH_W - TOTAL_W;

    // table geometry
    localparam int VALUE_BITS  = 10;
    localparam int TABLE_DEPTH = 1 << VALUE_BITS;
    localparam int EXT_W       = (VALUE_BITS > VALUE_W) ? VALUE_BITS : VALUE_W;

    // per-entry counter and array tag
    localparam int COUNT_W = MATCH_W;
    localparam int EPOCH_W = 8;

    typedef logic [VALUE_BITS-1:0] t_idx;
    typedef logic [COUNT_W-1:0]    t_count;
    typedef logic [EPOCH_W-1:0]    t_epoch;
    typedef logic [TOTAL_W-1:0]    t_total;

    localparam t_count COUNT_MAX  = '1;
    localparam t_total TOTAL_MAX  = '1;
    localparam t_epoch EPOCH_MAX  = '1;
    localparam t_epoch EPOCH_IDLE = '0;
    localparam t_idx   TABLE_LAST = t_idx'(TABLE_DEPTH - 1);

    // one table entry: array tag and occurrence count
    typedef struct packed {
        t_epoch tag;
        t_count count;
    } t_entry;

    // table write request
    typedef struct packed {
        logic   en;
        t_idx   addr;
        t_entry data;
    } t_ram_wr;

    // clear sequencer states
    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    // element or target field to table index
    function automatic t_idx to_index(logic [VALUE_W-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return ext[VALUE_BITS-1:0];
    endfunction

endpackage

// File: rtl/subarray_xor_count.sv
// ----------------------------------------------------------------------------
// subarray_xor_count
// Streaming count of subarrays whose XOR equals a programmable target.
// ----------------------------------------------------------------------------
// channel   | dir | handshake                      | word
// s stream  | in  | i_s_tvalid / o_s_tready        | tdata: value, tuser: start_req
// m stream  | out | o_m_tvalid / i_m_tready        | tdata: matches_here, total
// cfg write | in  | i_cfg_valid / o_cfg_ready      | data: target_xor
//
// one word per cycle unless a stall or clear pass holds it; a result word is
// offered via the registered two-port table read and the output register
// reset starts a clear pass over all 1024 table entries, no input word taken
// a start word arriving once the 255 array tags are used up waits for the
// lookup stage to empty and for another clear pass of the table
// a stalled result word holds the pipeline and the input stream
// ----------------------------------------------------------------------------
module subarray_xor_count (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [sxc_pkg::IN_TDATA_W-1:0]   i_s_tdata,   // [9:0] value
    input  logic                             i_s_tuser,   // [0] start_req
    // output stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [sxc_pkg::OUT_TDATA_W-1:0]  o_m_tdata,   // [16:0] matches_here,
                                                          // [48:17] total
    // configuration write
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sxc_pkg::TARGET_W-1:0]     i_cfg_data   // target_xor
);
    import sxc_pkg::*;

    // count of an entry as seen by an item of the given array tag
    function automatic t_count entry_count(t_idx addr, t_entry e, t_epoch ep);
        if (e.tag == ep) begin
            return e.count;
        end else if (addr == '0) begin
            return COUNT_W'(1);
        end else begin
            return '0;
        end
    endfunction

    logic [TARGET_W-1:0] r_target;
    t_idx    r_prefix;
    t_epoch  r_epoch;
    t_total  r_total;

    logic    r_s1_valid;
    logic    r_s1_start;
    t_idx    r_s1_prefix;
    t_idx    r_s1_need;
    t_epoch  r_s1_epoch;

    logic    r_out_valid;
    t_count  r_out_matches;
    t_total  r_out_total;

    logic    r_wr_valid;
    t_idx    r_wr_addr;
    t_entry  r_wr_data;

    logic    adv;
    logic    accept;
    logic    wrap_hold;
    logic    clear_req;
    logic    scrub_busy;
    logic    pipe_wr;

    t_idx    in_idx;
    t_idx    base_prefix;
    t_idx    cur_prefix;
    t_idx    need_idx;
    t_epoch  item_epoch;

    t_entry  rd_need;
    t_entry  rd_cur;
    t_entry  need_entry;
    t_entry  cur_entry;
    t_count  match_cnt;
    t_count  cur_count;
    t_count  inc_count;
    t_total  total_base;
    logic [TOTAL_W:0] total_sum;
    t_total  total_new;

    t_ram_wr scrub_wr;
    t_ram_wr ram_wr;

    // handshakes
    assign adv         = !r_out_valid || i_m_tready;
    assign wrap_hold   = i_s_tvalid && i_s_tuser && (r_epoch == EPOCH_MAX);
    assign clear_req   = wrap_hold && !r_s1_valid && !scrub_busy;
    assign o_s_tready  = adv && !scrub_busy && !wrap_hold;
    assign accept      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // prefix and lookup addresses of the incoming word
    assign in_idx      = to_index(i_s_tdata[VALUE_W-1:0]);
    assign base_prefix = i_s_tuser ? t_idx'(0) : r_prefix;
    assign cur_prefix  = base_prefix ^ in_idx;
    assign need_idx    = cur_prefix ^ to_index(r_target);
    assign item_epoch  = i_s_tuser ? (r_epoch + t_epoch'(1)) : r_epoch;

    // target register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_target <= i_cfg_data;
        end
    end

    // array state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= '0;
            r_epoch  <= t_epoch'(1);
        end else if (clear_req) begin
            r_epoch  <= EPOCH_IDLE;
        end else if (accept) begin
            r_prefix <= cur_prefix;
            r_epoch  <= item_epoch;
        end
    end

    // lookup stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // lookup stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_start  <= i_s_tuser;
            r_s1_prefix <= cur_prefix;
            r_s1_need   <= need_idx;
            r_s1_epoch  <= item_epoch;
        end
    end

    // occurrence table
    sxc_count_ram u_ram (
        .i_clk      (i_clk),
        .i_rd_en    (accept),
        .i_rd_addr0 (need_idx),
        .i_rd_addr1 (cur_prefix),
        .o_rd_data0 (rd_need),
        .o_rd_data1 (rd_cur),
        .i_wr       (ram_wr)
    );

    // clear sequencer
    sxc_scrub u_scrub (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (clear_req),
        .o_busy  (scrub_busy),
        .o_wr    (scrub_wr)
    );

    // forward the last write over the read that overlapped it
    always_comb begin
        need_entry = rd_need;
        cur_entry  = rd_cur;
        if (r_wr_valid && (r_wr_addr == r_s1_need)) begin
            need_entry = r_wr_data;
        end
        if (r_wr_valid && (r_wr_addr == r_s1_prefix)) begin
            cur_entry = r_wr_data;
        end
    end

    // counts, increment and saturating total
    assign match_cnt  = entry_count(r_s1_need, need_entry, r_s1_epoch);
    assign cur_count  = entry_count(r_s1_prefix, cur_entry, r_s1_epoch);
    assign inc_count  = (cur_count == COUNT_MAX) ? cur_count : (cur_count + t_count'(1));
    assign total_base = r_s1_start ? t_total'(0) : r_total;
    assign total_sum  = {1'b0, total_base} + (TOTAL_W + 1)'(match_cnt);
    assign total_new  = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

    // table write select
    assign pipe_wr = adv && r_s1_valid;
    always_comb begin
        if (scrub_busy) begin
            ram_wr = scrub_wr;
        end else begin
            ram_wr.en         = pipe_wr;
            ram_wr.addr       = r_s1_prefix;
            ram_wr.data.tag   = r_s1_epoch;
            ram_wr.data.count = inc_count;
        end
    end

    // running total and forwarding valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= '0;
            r_wr_valid <= 1'b0;
        end else if (scrub_busy) begin
            r_wr_valid <= 1'b0;
        end else if (pipe_wr) begin
            r_total    <= total_new;
            r_wr_valid <= 1'b1;
        end
    end

    // forwarding payload
    always_ff @(posedge i_clk) begin
        if (pipe_wr) begin
            r_wr_addr       <= r_s1_prefix;
            r_wr_data.tag   <= r_s1_epoch;
            r_wr_data.count <= inc_count;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (pipe_wr) begin
            r_out_matches <= match_cnt;
            r_out_total   <= total_new;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {OUT_PAD_W'(0), r_out_total, r_out_matches};

endmodule

// File: rtl/sxc_count_ram.sv
// ----------------------------------------------------------------------------
// sxc_count_ram
// Occurrence table: two registered read ports, one write port, read-old.
// ----------------------------------------------------------------------------
module sxc_count_ram (
    input  logic            i_clk,
    input  logic            i_rd_en,
    input  sxc_pkg::t_idx   i_rd_addr0,
    input  sxc_pkg::t_idx   i_rd_addr1,
    output sxc_pkg::t_entry o_rd_data0,
    output sxc_pkg::t_entry o_rd_data1,
    input  sxc_pkg::t_ram_wr i_wr
);
    import sxc_pkg::*;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd0;
    t_entry r_rd1;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read ports, data of the previous contents on a collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd0 <= r_mem[i_rd_addr0];
            r_rd1 <= r_mem[i_rd_addr1];
        end
    end

    assign o_rd_data0 = r_rd0;
    assign o_rd_data1 = r_rd1;

endmodule

// File: rtl/sxc_scrub.sv
// ----------------------------------------------------------------------------
// sxc_scrub
// Clear pass over the table after reset and when the array tags run out.
// ----------------------------------------------------------------------------
module sxc_scrub (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    output sxc_pkg::t_ram_wr o_wr
);
    import sxc_pkg::*;

    t_state r_state;
    t_state n_state;
    t_idx   r_ptr;
    t_idx   n_ptr;

    // state and pointer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
        end
    end

    // next state and write request
    always_comb begin
        n_state          = r_state;
        n_ptr            = r_ptr;
        o_busy           = 1'b0;
        o_wr.en          = 1'b0;
        o_wr.addr        = r_ptr;
        o_wr.data.tag    = EPOCH_IDLE;
        o_wr.data.count  = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_busy  = 1'b1;
                o_wr.en = 1'b1;
                n_ptr   = r_ptr + t_idx'(1);
                if (r_ptr == TABLE_LAST) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_start) begin
                    n_state = ST_CLEAR;
                    n_ptr   = '0;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_ptr   = '0;
            end
        endcase
    end

endmodule

// File: rtl/sxc_checker.sv
// ----------------------------------------------------------------------------
// sxc_checker
// Port-level checks of the subarray XOR counter, bound to the top level.
// ----------------------------------------------------------------------------
module sxc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [sxc_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import sxc_pkg::*;

    // reset starts the clear pass, no word taken right after
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("input ready right after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result word changed");

    // a new result word comes from an input word taken earlier, through the lookup stage and output register
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready, 2))
        else $error("result word without a matching input word");

    // padding of the result word stays zero
    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] == '0))
        else $error("result word padding not zero");

endmodule

bind subarray_xor_count sxc_checker u_sxc_checker (.*);
